// ===== src/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Types, constants and helper functions for the IR remote pulse decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int TIME_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SIL_W      = 15;
    localparam int CNT_W      = 6;

    localparam logic [CNT_W-1:0] FRAME_BITS = 6'd32;
    localparam logic [CNT_W-1:0] KEEP_LO    = 6'd16;
    localparam logic [CNT_W-1:0] KEEP_HI    = 6'd18;

    localparam logic [SIL_W-1:0]  SILENCE_LIMIT_RST   = 15'd27500;
    localparam logic [TIME_W-1:0] START_LOW_MIN_RST   = 16'd2200;
    localparam logic [TIME_W-1:0] START_IDLE_MIN_RST  = 16'd1000;
    localparam logic [TIME_W-1:0] BIT_ONE_MIN_RST     = 16'd375;
    localparam logic [TIME_W-1:0] REPEAT_IDLE_MIN_RST = 16'd500;

    localparam logic [3:0] DRV_STOP  = 4'b0000;
    localparam logic [3:0] DRV_FWD   = 4'b0101;
    localparam logic [3:0] DRV_BACK  = 4'b1010;
    localparam logic [3:0] DRV_LEFT  = 4'b0110;
    localparam logic [3:0] DRV_RIGHT = 4'b1001;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_LEAD_LOW   = 4'd1,
        ST_LEAD_SPACE = 4'd2,
        ST_BIT_LOW    = 4'd3,
        ST_BIT_SPACE  = 4'd4,
        ST_REP_LOW1   = 4'd5,
        ST_REP_SPACE1 = 4'd6,
        ST_REP_LOW2   = 4'd7,
        ST_REP_SPACE2 = 4'd8
    } dec_state_t;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_UP    = 3'd1,
        KEY_LEFT  = 3'd2,
        KEY_RIGHT = 3'd3,
        KEY_DOWN  = 3'd4,
        KEY_OK    = 3'd5,
        KEY_ZERO  = 3'd6
    } key_t;

    typedef enum logic [2:0] {
        CFG_SILENCE_LIMIT   = 3'd0,
        CFG_START_LOW_MIN   = 3'd1,
        CFG_START_IDLE_MIN  = 3'd2,
        CFG_BIT_ONE_MIN     = 3'd3,
        CFG_REPEAT_IDLE_MIN = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MOT_STOP  = 3'd0,
        MOT_FWD   = 3'd1,
        MOT_LEFT  = 3'd2,
        MOT_RIGHT = 3'd3,
        MOT_BACK  = 3'd4
    } motion_t;

    // kept frame bits to key, no key until a frame has completed
    function automatic key_t key_of_bits(input logic [2:0] bits, input logic ready);
        key_t k;
        begin
            if (!ready)
                k = KEY_NONE;
            else if (bits[0])
                k = bits[1] ? KEY_RIGHT : KEY_DOWN;
            else if (bits[1])
                k = bits[2] ? KEY_UP : KEY_ZERO;
            else
                k = bits[2] ? KEY_LEFT : KEY_OK;
            return k;
        end
    endfunction

    // motion to bridge code, unknown motion keeps the old code
    function automatic logic [3:0] drive_of_motion(input logic [7:0] motion,
                                                   input logic [3:0] old_code);
        logic [3:0] c;
        begin
            case (motion)
                8'(MOT_STOP):  c = DRV_STOP;
                8'(MOT_FWD):   c = DRV_FWD;
                8'(MOT_LEFT):  c = DRV_LEFT;
                8'(MOT_RIGHT): c = DRV_RIGHT;
                8'(MOT_BACK):  c = DRV_BACK;
                default:       c = old_code;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== src/ir_remote_pulse_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder_unit
// Pulse-distance IR remote decoder with key mapping and motor drive select.
// ----------------------------------------------------------------------------
// One poll item is taken per clock. Its result appears in the output register
// on the next cycle; decoder state and result are computed in the same cycle
// the item is accepted. in_ready stays high while the output register is
// empty or being drained, so a steady stream runs at one item per cycle and
// only a stalled output holds the input back. Configuration registers reset
// to their defaults; no clearing pass is needed after reset.
module ir_remote_pulse_decoder_unit
    import irpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_W-1:0]    now_time,
    input  logic [TIME_W-1:0]    edge_time,
    input  logic                 edge_level,
    input  logic [7:0]           auto_command,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           motor_code,
    output logic                 trigger_out,
    output logic                 auto_on,
    output logic [2:0]           key_code
);

    logic [SIL_W-1:0]  silence_limit_reg;
    logic [TIME_W-1:0] start_low_min_reg;
    logic [TIME_W-1:0] start_idle_min_reg;
    logic [TIME_W-1:0] bit_one_min_reg;
    logic [TIME_W-1:0] repeat_idle_min_reg;

    dec_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [TIME_W-1:0] mark_time_reg, mark_time_next;
    logic [2:0]        kept_bits_reg, kept_bits_next;
    logic              frame_ready_reg, frame_ready_next;
    key_t              previous_key_reg;
    logic              auto_mode_reg, auto_mode_next;
    logic [3:0]        drive_code_reg, drive_code_next;

    logic              out_valid_reg;
    logic [3:0]        motor_code_reg;
    logic              trigger_out_reg;
    logic              auto_on_reg;
    logic [2:0]        key_code_reg;

    logic              accept;
    logic [TIME_W-1:0] quiet;
    logic [TIME_W-1:0] dur;
    logic              silent;
    logic [CNT_W-1:0]  keep_off;
    key_t              key;
    logic [7:0]        motion;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_limit_reg   <= SILENCE_LIMIT_RST;
            start_low_min_reg   <= START_LOW_MIN_RST;
            start_idle_min_reg  <= START_IDLE_MIN_RST;
            bit_one_min_reg     <= BIT_ONE_MIN_RST;
            repeat_idle_min_reg <= REPEAT_IDLE_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SILENCE_LIMIT:   silence_limit_reg   <= cfg_wdata[SIL_W-1:0];
                CFG_START_LOW_MIN:   start_low_min_reg   <= cfg_wdata;
                CFG_START_IDLE_MIN:  start_idle_min_reg  <= cfg_wdata;
                CFG_BIT_ONE_MIN:     bit_one_min_reg     <= cfg_wdata;
                CFG_REPEAT_IDLE_MIN: repeat_idle_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a negative gap (wrapped) never counts as silence
    assign quiet    = now_time - edge_time;
    assign silent   = !quiet[TIME_W-1] && (quiet[SIL_W-1:0] > silence_limit_reg);
    assign dur      = edge_time - mark_time_reg;
    assign keep_off = bit_count_reg - KEEP_LO;

    always_comb
    begin
        state_next       = state_reg;
        bit_count_next   = bit_count_reg;
        mark_time_next   = mark_time_reg;
        kept_bits_next   = kept_bits_reg;
        frame_ready_next = frame_ready_reg;

        if (silent)
        begin
            state_next       = ST_IDLE;
            bit_count_next   = '0;
            frame_ready_next = 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!edge_level)
                    begin
                        mark_time_next = edge_time;
                        state_next     = ST_LEAD_LOW;
                    end
                end
                ST_LEAD_LOW:
                begin
                    if (edge_level)
                    begin
                        if (dur > start_low_min_reg)
                        begin
                            mark_time_next = edge_time;
                            state_next     = ST_LEAD_SPACE;
                        end
                        else
                            state_next = ST_IDLE;
                    end
                end
                ST_LEAD_SPACE:
                begin
                    if (!edge_level)
                    begin
                        if (dur > start_idle_min_reg)
                        begin
                            mark_time_next = edge_time;
                            state_next     = ST_BIT_LOW;
                        end
                        else
                            state_next = ST_IDLE;
                    end
                end
                ST_BIT_LOW:
                begin
                    if (edge_level)
                        state_next = ST_BIT_SPACE;
                end
                ST_BIT_SPACE:
                begin
                    if (!edge_level)
                    begin
                        if (bit_count_reg == FRAME_BITS)
                        begin
                            state_next       = ST_REP_LOW1;
                            frame_ready_next = 1'b1;
                        end
                        else
                        begin
                            if (bit_count_reg >= KEEP_LO && bit_count_reg <= KEEP_HI)
                                kept_bits_next[keep_off[1:0]] = (dur >= bit_one_min_reg);
                            mark_time_next   = edge_time;
                            bit_count_next   = bit_count_reg + CNT_W'(1);
                            state_next       = ST_BIT_LOW;
                            frame_ready_next = 1'b0;
                        end
                    end
                end
                ST_REP_LOW1:
                begin
                    if (edge_level)
                    begin
                        if (dur > start_low_min_reg)
                        begin
                            mark_time_next = edge_time;
                            state_next     = ST_REP_SPACE1;
                        end
                        else
                            state_next = ST_REP_SPACE2;
                    end
                end
                ST_REP_SPACE1:
                begin
                    // a long space is a fresh frame, a shorter one above the repeat minimum a repeat
                    if (!edge_level)
                    begin
                        if (dur > start_idle_min_reg)
                        begin
                            mark_time_next = edge_time;
                            state_next     = ST_BIT_LOW;
                            bit_count_next = '0;
                        end
                        else if (dur > repeat_idle_min_reg)
                        begin
                            mark_time_next = edge_time;
                            state_next     = ST_REP_LOW2;
                        end
                    end
                end
                ST_REP_LOW2:
                begin
                    if (edge_level)
                        state_next = ST_REP_SPACE2;
                end
                ST_REP_SPACE2:
                begin
                    if (!edge_level)
                    begin
                        mark_time_next = edge_time;
                        state_next     = ST_REP_LOW1;
                    end
                end
                default:
                    state_next = ST_IDLE;
            endcase
        end

        key = key_of_bits(kept_bits_next, frame_ready_next);

        // zero key toggles auto mode on a new press only
        auto_mode_next = auto_mode_reg;
        if (key == KEY_ZERO && previous_key_reg != KEY_ZERO)
            auto_mode_next = !auto_mode_reg;

        if (auto_mode_next)
            motion = auto_command;
        else if (key == KEY_OK || key == KEY_ZERO)
            motion = 8'(MOT_STOP);
        else
            motion = 8'(key);
        drive_code_next = drive_of_motion(motion, drive_code_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bit_count_reg    <= '0;
            mark_time_reg    <= '0;
            kept_bits_reg    <= '0;
            frame_ready_reg  <= 1'b0;
            previous_key_reg <= KEY_NONE;
            auto_mode_reg    <= 1'b0;
            drive_code_reg   <= DRV_STOP;
        end
        else if (accept)
        begin
            state_reg        <= state_next;
            bit_count_reg    <= bit_count_next;
            mark_time_reg    <= mark_time_next;
            kept_bits_reg    <= kept_bits_next;
            frame_ready_reg  <= frame_ready_next;
            previous_key_reg <= key;
            auto_mode_reg    <= auto_mode_next;
            drive_code_reg   <= drive_code_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            motor_code_reg  <= drive_code_next;
            trigger_out_reg <= (key == KEY_OK);
            auto_on_reg     <= auto_mode_next;
            key_code_reg    <= key;
        end
    end

    assign out_valid   = out_valid_reg;
    assign motor_code  = motor_code_reg;
    assign trigger_out = trigger_out_reg;
    assign auto_on     = auto_on_reg;
    assign key_code    = key_code_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_drive_legal: assert property (@(posedge clk) disable iff (!rst_n)
        drive_code_reg == DRV_STOP || drive_code_reg == DRV_FWD ||
        drive_code_reg == DRV_BACK || drive_code_reg == DRV_LEFT ||
        drive_code_reg == DRV_RIGHT)
        else $error("drive code outside bridge patterns");

    a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= FRAME_BITS)
        else $error("bit count ran past frame length");

    a_trigger_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (trigger_out_reg == (key_code_reg == KEY_OK)) &&
                   (auto_on_reg == auto_mode_reg))
        else $error("result fields disagree with key and mode");

endmodule
